[src/wbe_pkg.sv]
`default_nettype none
package wbe_pkg;

  // defaults for the top-level parameters
  localparam int SYMBOLS_PER_BLOCK_DEF = 2;
  localparam int GENUS_DEF             = 4;

  // fixed field widths
  localparam int ROW_W    = 1;
  localparam int COL_W    = 3;
  localparam int COEF_W   = 8;
  localparam int SAMPLE_W = 12;

  localparam int SAMPLE_MAX = 2047;
  localparam int SAMPLE_MIN = -2048;

  // func codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_ENCODE = 1'b1;

  // microprogram steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_ERD,
    S_ELD,
    S_END,
    S_CLR
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_TRIG,
    C_MAC_LAST,
    C_EMIT_LAST,
    C_CLR_LAST
  } cond_t;

  typedef struct packed {
    logic  in_rdy;   // take an input beat
    logic  mac;      // issue one multiply-accumulate read
    logic  emit_rd;  // read the next sample to emit
    logic  emit_ld;  // load the output register, zero the entry
    logic  fin;      // close the block
    logic  clr;      // clear one accumulator entry
    logic  hold;     // stay while the output register is busy
    cond_t cond;
    step_t jmp;      // next step when cond holds
    step_t nxt;      // next step otherwise
  } uword_t;

  // datapath strobes
  typedef struct packed {
    logic in_rdy;
    logic mac;
    logic emit_rd;
    logic emit_ld;
    logic fin;
    logic clr;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic trig;
    logic mac_last;
    logic emit_last;
    logic clr_last;
    logic out_busy;
  } stat_t;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{in_rdy: 1'b0, mac: 1'b0, emit_rd: 1'b0, emit_ld: 1'b0, fin: 1'b0,
          clr: 1'b0, hold: 1'b0, cond: C_ALWAYS, jmp: S_IDLE, nxt: S_IDLE};
    case (s)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_TRIG;
        w.jmp    = S_MAC;
        w.nxt    = S_IDLE;
      end
      S_MAC: begin
        w.mac  = 1'b1;
        w.cond = C_MAC_LAST;
        w.jmp  = S_DRAIN;
        w.nxt  = S_MAC;
      end
      S_DRAIN: begin
        w.jmp = S_ERD;
      end
      S_ERD: begin
        w.emit_rd = 1'b1;
        w.jmp     = S_ELD;
      end
      S_ELD: begin
        w.emit_ld = 1'b1;
        w.hold    = 1'b1;
        w.cond    = C_EMIT_LAST;
        w.jmp     = S_END;
        w.nxt     = S_ERD;
      end
      S_END: begin
        w.fin = 1'b1;
        w.jmp = S_IDLE;
      end
      S_CLR: begin
        w.clr  = 1'b1;
        w.cond = C_CLR_LAST;
        w.jmp  = S_IDLE;
        w.nxt  = S_CLR;
      end
      default: begin
        w.jmp = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[src/wbe_ifs.sv]
`default_nettype none
interface wbe_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [wbe_pkg::ROW_W-1:0]         coef_row;
  logic [wbe_pkg::COL_W-1:0]         coef_col;
  logic signed [wbe_pkg::COEF_W-1:0] coef_value;
  logic                              symbol_bit;
  logic                              frame_end;

  modport source (output valid, func, coef_row, coef_col, coef_value, symbol_bit,
                  frame_end, input ready);
  modport sink (input valid, func, coef_row, coef_col, coef_value, symbol_bit,
                frame_end, output ready);
endinterface

interface wbe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wbe_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface
`default_nettype wire

[src/wbe_ram.sv]
`default_nettype none
module wbe_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[src/wbe_seq.sv]
`default_nettype none
module wbe_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wbe_pkg::stat_t stat,
  output wbe_pkg::ctl_t       ctl
);
  wbe_pkg::step_t  step;
  wbe_pkg::step_t  step_next;
  wbe_pkg::uword_t uw;
  logic            cond_ok;
  logic            holding;

  assign uw      = wbe_pkg::ucode(step);
  assign holding = uw.hold && stat.out_busy;

  always_comb begin
    case (uw.cond)
      wbe_pkg::C_ALWAYS:    cond_ok = 1'b1;
      wbe_pkg::C_TRIG:      cond_ok = stat.trig;
      wbe_pkg::C_MAC_LAST:  cond_ok = stat.mac_last;
      wbe_pkg::C_EMIT_LAST: cond_ok = stat.emit_last;
      wbe_pkg::C_CLR_LAST:  cond_ok = stat.clr_last;
      default:              cond_ok = 1'b1;
    endcase
    if (holding) begin
      step_next = step;
    end else if (cond_ok) begin
      step_next = uw.jmp;
    end else begin
      step_next = uw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= wbe_pkg::S_CLR;
    end else begin
      step <= step_next;
    end
  end

  assign ctl.in_rdy  = uw.in_rdy;
  assign ctl.mac     = uw.mac;
  assign ctl.emit_rd = uw.emit_rd;
  assign ctl.emit_ld = uw.emit_ld && !holding;
  assign ctl.fin     = uw.fin;
  assign ctl.clr     = uw.clr;
endmodule
`default_nettype wire

[src/wbe_dp.sv]
`default_nettype none
module wbe_dp #(
  parameter int SYMBOLS_PER_BLOCK = wbe_pkg::SYMBOLS_PER_BLOCK_DEF,
  parameter int GENUS             = wbe_pkg::GENUS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  wbe_in_if.sink             din,
  wbe_out_if.source          dout,
  input  wire wbe_pkg::ctl_t ctl,
  output wbe_pkg::stat_t     stat
);
  localparam int M        = SYMBOLS_PER_BLOCK;
  localparam int SPAN     = SYMBOLS_PER_BLOCK * GENUS;
  localparam int J_W      = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int CNT_W    = (M > 1) ? $clog2(M) : 1;
  localparam int NB_W     = $clog2(M + 1);
  localparam int CA_DEPTH = M * SPAN;
  localparam int CA_W     = (CA_DEPTH > 1) ? $clog2(CA_DEPTH) : 1;
  localparam int ACC_RAW  = $clog2(SPAN * 128 + 1) + 1;
  localparam int ACC_W    = (ACC_RAW < wbe_pkg::SAMPLE_W) ? wbe_pkg::SAMPLE_W : ACC_RAW;
  localparam int SW       = wbe_pkg::SAMPLE_W;
  localparam int CW       = wbe_pkg::COEF_W;

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(wbe_pkg::SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(wbe_pkg::SAMPLE_MIN);

  // block state
  logic [CNT_W-1:0] cnt;
  logic [M-1:0]     pending;
  logic [NB_W-1:0]  blk_n;
  logic             fend_q;
  logic [J_W-1:0]   base;

  // loop counters
  logic [J_W-1:0]   j;
  logic [CNT_W-1:0] k;
  logic [CA_W-1:0]  ca;
  logic [J_W-1:0]   e;

  // accumulate stage
  logic                    p_valid;
  logic                    p_sym;
  logic [J_W-1:0]          p_addr;
  logic                    fwd_q;
  logic signed [ACC_W-1:0] fwd_d;

  logic                    accept;
  logic                    is_enc;
  logic                    ld_ok;
  logic [CA_W-1:0]         ld_addr;
  logic [M-1:0]            pending_ins;
  logic [M-1:0]            pend_sh;
  logic [J_W:0]            psum;
  logic [J_W-1:0]          phys;
  logic [J_W:0]            bsum;
  logic [J_W-1:0]          base_next;

  logic [CW-1:0]           coef_rdata;
  logic [ACC_W-1:0]        acc_rdata;
  logic signed [ACC_W-1:0] acc_old;
  logic signed [ACC_W-1:0] coef_x;
  logic signed [ACC_W-1:0] mac_sum;
  logic signed [ACC_W-1:0] acc_s;
  logic signed [SW-1:0]    sat;

  logic                    acc_we;
  logic [J_W-1:0]          acc_waddr;
  logic [ACC_W-1:0]        acc_wdata;

  assign accept = din.valid && din.ready;
  assign is_enc = (din.func == wbe_pkg::FUNC_ENCODE);
  assign din.ready = ctl.in_rdy;

  assign ld_ok   = accept && !is_enc && (int'(din.coef_row) < M) && (int'(din.coef_col) < SPAN);
  assign ld_addr = CA_W'(int'(din.coef_row) * SPAN + int'(din.coef_col));

  assign pending_ins = pending | (M'(din.symbol_bit) << cnt);
  assign pend_sh     = pending >> k;

  // circular accumulator: logical index + base, wrapped
  assign psum = {1'b0, base} + {1'b0, (ctl.mac ? j : e)};
  assign phys = (psum >= (J_W+1)'(SPAN)) ? J_W'(psum - (J_W+1)'(SPAN)) : J_W'(psum);
  assign bsum = {1'b0, base} + (J_W+1)'(M);
  assign base_next = (bsum >= (J_W+1)'(SPAN)) ? J_W'(bsum - (J_W+1)'(SPAN)) : J_W'(bsum);

  assign stat.trig      = din.valid && is_enc && ((int'(cnt) + 1 == M) || din.frame_end);
  assign stat.mac_last  = (j == J_W'(SPAN - 1)) && (int'(k) + 1 == int'(blk_n));
  assign stat.emit_last = (e == (fend_q ? J_W'(SPAN - 1) : J_W'(M - 1)));
  assign stat.clr_last  = (e == J_W'(SPAN - 1));
  assign stat.out_busy  = dout.valid && !dout.ready;

  // add or subtract one coefficient
  assign acc_old = fwd_q ? fwd_d : $signed(acc_rdata);
  assign coef_x  = {{(ACC_W-CW){coef_rdata[CW-1]}}, coef_rdata};
  assign mac_sum = p_sym ? (acc_old + coef_x) : (acc_old - coef_x);

  assign acc_s = $signed(acc_rdata);
  assign sat   = (acc_s > ACC_HI) ? SW'(wbe_pkg::SAMPLE_MAX) :
                 (acc_s < ACC_LO) ? SW'(wbe_pkg::SAMPLE_MIN) : acc_s[SW-1:0];

  assign acc_we    = p_valid || ctl.emit_ld || ctl.clr;
  assign acc_waddr = p_valid ? p_addr : (ctl.clr ? e : phys);
  assign acc_wdata = p_valid ? ACC_W'(mac_sum) : '0;

  wbe_ram #(.WIDTH(CW), .DEPTH(CA_DEPTH)) u_coef (
    .clk   (clk),
    .we    (ld_ok),
    .waddr (ld_addr),
    .wdata (din.coef_value),
    .re    (ctl.mac),
    .raddr (ca),
    .rdata (coef_rdata)
  );

  wbe_ram #(.WIDTH(ACC_W), .DEPTH(SPAN)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (ctl.mac || ctl.emit_rd),
    .raddr (phys),
    .rdata (acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pending    <= '0;
      base       <= '0;
      j          <= '0;
      k          <= '0;
      ca         <= '0;
      e          <= '0;
      p_valid    <= 1'b0;
      fwd_q      <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (accept && is_enc) begin
        pending <= pending_ins;
        if (stat.trig) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end

      if (ctl.mac) begin
        if (stat.mac_last) begin
          j  <= '0;
          k  <= '0;
          ca <= '0;
        end else begin
          ca <= ca + 1'b1;
          if (j == J_W'(SPAN - 1)) begin
            j <= '0;
            k <= k + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
      end

      p_valid <= ctl.mac;
      fwd_q   <= ctl.mac && p_valid && (p_addr == phys);

      if (ctl.emit_ld) begin
        e <= stat.emit_last ? '0 : e + 1'b1;
      end else if (ctl.clr) begin
        e <= stat.clr_last ? '0 : e + 1'b1;
      end

      if (ctl.fin) begin
        pending <= '0;
        if (!fend_q) begin
          base <= base_next;
        end
      end

      if (ctl.emit_ld) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && stat.trig) begin
      blk_n  <= NB_W'(int'(cnt) + 1);
      fend_q <= din.frame_end;
    end
    if (ctl.mac) begin
      p_sym  <= pend_sh[0];
      p_addr <= phys;
    end
    fwd_d <= mac_sum;
    if (ctl.emit_ld) begin
      dout.sample <= sat;
      dout.last   <= fend_q && (e == J_W'(SPAN - 1));
    end
  end
endmodule
`default_nettype wire

[src/wavelet_block_encoder_core.sv]
`default_nettype none
// channel  dir  handshake      beat
// -------  ---  -------------  ------------------------------------------------
// din      in   valid / ready  func, coef_row, coef_col, coef_value,
//                              symbol_bit, frame_end
// dout     out  valid / ready  sample, last
//
// A load beat, or a symbol that leaves its block open, is taken while idle. A
// symbol that closes a block of n symbols runs the accumulate loop (n*M*G
// coefficients, one per cycle through the coefficient RAM), a drain step, a
// read and a load step per emitted sample and a closing step; M samples are
// emitted, M*G on frame_end. After rst all M*G accumulator entries are cleared
// before din is ready. A stall on dout holds the sequencer in its emit step;
// din is not taken until all samples of the block reach the output register.
module wavelet_block_encoder_core #(
  parameter int SYMBOLS_PER_BLOCK = wbe_pkg::SYMBOLS_PER_BLOCK_DEF,
  parameter int GENUS             = wbe_pkg::GENUS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  wbe_in_if.sink    din,
  wbe_out_if.source dout
);
  // sequencer <-> datapath
  wbe_pkg::ctl_t  ctl;
  wbe_pkg::stat_t stat;

  // microcoded control: step counter, control store, jump select
  wbe_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // coefficient RAM, circular accumulator RAM, counters, output register
  wbe_dp #(
    .SYMBOLS_PER_BLOCK (SYMBOLS_PER_BLOCK),
    .GENUS             (GENUS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .ctl  (ctl),
    .stat (stat)
  );
endmodule
`default_nettype wire
